// ===== rtl/bmt_pkg.sv =====
// ----------------------------------------------------------------------------
// bmt_pkg: shared definitions for the breakpoint match table
// Field widths, op codes, the no-line marker and the default store depths.
// ----------------------------------------------------------------------------
package bmt_pkg;

    localparam int OP_W   = 3;
    localparam int MOD_W  = 8;
    localparam int LINE_W = 21;

    // op codes
    localparam logic [OP_W-1:0] OP_HIT_CHECK = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_PERS  = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_ONCE  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_PERS  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd4;

    // line number -1: no line
    localparam logic signed [LINE_W-1:0] LINE_NONE = '1;

    localparam int PERSISTENT_DEPTH_DEF = 16;
    localparam int ONESHOT_DEPTH_DEF    = 8;

endpackage

// ===== rtl/bmt_req_if.sv =====
// ----------------------------------------------------------------------------
// bmt_req_if: request channel of the breakpoint match table
// Valid/ready handshake carrying one op with its key and enable flag.
// ----------------------------------------------------------------------------
interface bmt_req_if;

    logic                                    valid;
    logic                                    ready;
    logic        [bmt_pkg::OP_W-1:0]         op;
    logic        [bmt_pkg::MOD_W-1:0]        module_id;
    logic signed [bmt_pkg::LINE_W-1:0]       line_no;
    logic                                    enable_flag;

    modport source (output valid, output op, output module_id, output line_no,
                    output enable_flag, input ready);
    modport sink   (input valid, input op, input module_id, input line_no,
                    input enable_flag, output ready);

endinterface

// ===== rtl/bmt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bmt_rsp_if: response channel of the breakpoint match table
// Valid/ready handshake carrying the hit flag and the insert status.
// ----------------------------------------------------------------------------
interface bmt_rsp_if;

    logic valid;
    logic ready;
    logic hit;
    logic status;

    modport source (output valid, output hit, output status, input ready);
    modport sink   (input valid, input hit, input status, output ready);

endinterface

// ===== rtl/breakpoint_match_table.sv =====
// ----------------------------------------------------------------------------
// breakpoint_match_table: associative breakpoint table keyed by (module, line)
// Persistent entries with an enabled flag plus one-shot entries, all held in
// flip-flops and compared in parallel.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one transfer per op: hit check, set persistent, set one-shot,
//          remove persistent, clear all. Key is (module_id, line_no).
//   rsp  - exactly one transfer per request: hit and status (status = 1
//          when an insert found its store full and was dropped).
// Pipeline: a request is taken into the input register and decoded from it;
//   the table updates and the response is loaded into the output register
//   at the same edge.
// Throughput: one request per cycle while responses are taken. Every entry
//   of both stores is compared against the key in the same cycle, so the
//   next request sees the table as this one left it.
// Reset: all valid bits cleared, both channels empty. Clear all does the
//   same to the stores.
// Stall: while rsp.ready is low the result holds in the output register;
//   one more request may sit in the input register, then req.ready drops.
// ----------------------------------------------------------------------------
module breakpoint_match_table #(
    parameter int PERSISTENT_DEPTH = bmt_pkg::PERSISTENT_DEPTH_DEF,
    parameter int ONESHOT_DEPTH    = bmt_pkg::ONESHOT_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bmt_req_if.sink   req,
    bmt_rsp_if.source rsp
);

    localparam int PD = PERSISTENT_DEPTH;
    localparam int OD = ONESHOT_DEPTH;

    // input register
    logic                               in_valid_reg;
    logic [bmt_pkg::OP_W-1:0]           op_reg;
    logic [bmt_pkg::MOD_W-1:0]          mod_reg;
    logic signed [bmt_pkg::LINE_W-1:0]  line_reg;
    logic                               en_reg;

    // output register
    logic out_valid_reg, out_valid_next;
    logic hit_reg, hit_next;
    logic status_reg, status_next;

    // persistent store
    logic [PD-1:0]                      p_valid_reg, p_valid_next;
    logic [PD-1:0]                      p_en_reg, p_en_next;
    logic [bmt_pkg::MOD_W-1:0]          p_mod_reg  [PD];
    logic signed [bmt_pkg::LINE_W-1:0]  p_line_reg [PD];

    // one-shot store
    logic [OD-1:0]                      o_valid_reg, o_valid_next;
    logic [bmt_pkg::MOD_W-1:0]          o_mod_reg  [OD];
    logic signed [bmt_pkg::LINE_W-1:0]  o_line_reg [OD];

    logic advance, fire;
    logic [PD-1:0] p_match, p_free, p_first, p_alloc, p_clr, p_wr;
    logic [OD-1:0] o_match, o_free, o_first, o_alloc, o_clr;
    logic          clear_all;

    // Handshake: input register drains whenever the output register can load.
    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;

    // Parallel key compare; each store holds a key at most once, so the
    // match vectors are one-hot or zero.
    always_comb
    begin
        for (int i = 0; i < PD; i++)
        begin
            p_match[i] = p_valid_reg[i] && (p_mod_reg[i] == mod_reg)
                         && (p_line_reg[i] == line_reg);
        end
        for (int j = 0; j < OD; j++)
        begin
            o_match[j] = o_valid_reg[j] && (o_mod_reg[j] == mod_reg)
                         && (o_line_reg[j] == line_reg);
        end
    end

    // lowest free slot, isolated as a one-hot vector
    assign p_free  = ~p_valid_reg;
    assign p_first = p_free & (~p_free + PD'(1));
    assign o_free  = ~o_valid_reg;
    assign o_first = o_free & (~o_free + OD'(1));

    // op decode
    always_comb
    begin
        hit_next    = 1'b0;
        status_next = 1'b0;
        p_alloc     = '0;
        p_clr       = '0;
        p_wr        = '0;
        o_alloc     = '0;
        o_clr       = '0;
        clear_all   = 1'b0;
        case (op_reg)
            bmt_pkg::OP_HIT_CHECK:
            begin
                if (line_reg != bmt_pkg::LINE_NONE)
                begin
                    if (|o_match)
                    begin
                        // one-shot wins and is consumed
                        hit_next = 1'b1;
                        o_clr    = o_match;
                    end
                    else
                    begin
                        hit_next = |(p_match & p_en_reg);
                    end
                end
            end
            bmt_pkg::OP_SET_PERS:
            begin
                if (|p_match)
                begin
                    p_wr = p_match;
                end
                else if (|p_free)
                begin
                    p_alloc = p_first;
                    p_wr    = p_first;
                end
                else
                begin
                    status_next = 1'b1;
                end
            end
            bmt_pkg::OP_SET_ONCE:
            begin
                if (!(|o_match))
                begin
                    if (|o_free)
                    begin
                        o_alloc = o_first;
                    end
                    else
                    begin
                        status_next = 1'b1;
                    end
                end
            end
            bmt_pkg::OP_DEL_PERS:
            begin
                p_clr = p_match;
            end
            bmt_pkg::OP_CLEAR_ALL:
            begin
                clear_all = 1'b1;
            end
            default:
            begin
                // unused codes: no effect
            end
        endcase
    end

    // store next state
    always_comb
    begin
        p_valid_next = p_valid_reg;
        p_en_next    = p_en_reg;
        o_valid_next = o_valid_reg;
        if (fire)
        begin
            if (clear_all)
            begin
                p_valid_next = '0;
                o_valid_next = '0;
            end
            else
            begin
                p_valid_next = (p_valid_reg & ~p_clr) | p_alloc;
                p_en_next    = (p_en_reg & ~p_wr) | (p_wr & {PD{en_reg}});
                o_valid_next = (o_valid_reg & ~o_clr) | o_alloc;
            end
        end
    end

    assign out_valid_next = fire || (out_valid_reg && !rsp.ready);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            p_valid_reg   <= '0;
            o_valid_reg   <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            out_valid_reg <= out_valid_next;
            p_valid_reg   <= p_valid_next;
            o_valid_reg   <= o_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg   <= req.op;
            mod_reg  <= req.module_id;
            line_reg <= req.line_no;
            en_reg   <= req.enable_flag;
        end
        if (fire)
        begin
            hit_reg    <= hit_next;
            status_reg <= status_next;
        end
        p_en_reg <= p_en_next;
        for (int i = 0; i < PD; i++)
        begin
            if (fire && p_alloc[i])
            begin
                p_mod_reg[i]  <= mod_reg;
                p_line_reg[i] <= line_reg;
            end
        end
        for (int j = 0; j < OD; j++)
        begin
            if (fire && o_alloc[j])
            begin
                o_mod_reg[j]  <= mod_reg;
                o_line_reg[j] <= line_reg;
            end
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.hit    = hit_reg;
    assign rsp.status = status_reg;

endmodule
